[rtl/dpt_pkg.sv]
// ----------------------------------------------------------------------------
// dpt_pkg
// Shared types and constants of the drum pad trigger to MIDI block.
// ----------------------------------------------------------------------------
`default_nettype none

package dpt_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int TIME_BITS   = 16;
    localparam int VEL_SHIFT   = SAMPLE_BITS - 7;
    localparam int MAX_EVENTS  = 8;
    localparam int PAD_SLOTS   = 7;
    localparam int CFG_BITS    = 16;

    localparam logic [2:0] HIHAT_SLOT = 3'd6;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_WAIT = 2'd1;
    localparam logic [1:0] PH_ON   = 2'd2;

    localparam logic [1:0] POS_OPEN   = 2'd0;
    localparam logic [1:0] POS_SEMI   = 2'd1;
    localparam logic [1:0] POS_CLOSED = 2'd2;

    localparam logic [6:0] NOTE_CRASH        = 7'd49;
    localparam logic [6:0] NOTE_TOM1         = 7'd50;
    localparam logic [6:0] NOTE_TOM2         = 7'd47;
    localparam logic [6:0] NOTE_TOM3         = 7'd41;
    localparam logic [6:0] NOTE_RIDE         = 7'd51;
    localparam logic [6:0] NOTE_KICK         = 7'd35;
    localparam logic [6:0] NOTE_HIHAT_OPEN   = 7'd46;
    localparam logic [6:0] NOTE_HIHAT_CLOSED = 7'd42;
    localparam logic [6:0] NOTE_PEDAL        = 7'd44;
    localparam logic [6:0] VEL_MAX           = 7'd127;

    localparam logic [2:0] CFG_NOTE_THRESHOLD   = 3'd0;
    localparam logic [2:0] CFG_NOTE_HOLD        = 3'd1;
    localparam logic [2:0] CFG_PEDAL_OPEN       = 3'd2;
    localparam logic [2:0] CFG_PEDAL_CLOSED     = 3'd3;
    localparam logic [2:0] CFG_PEDAL_WINDOW     = 3'd4;
    localparam logic [2:0] CFG_PEDAL_VEL_DIV    = 3'd5;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] crash_level;
        logic [SAMPLE_BITS-1:0] tom1_level;
        logic [SAMPLE_BITS-1:0] tom2_level;
        logic [SAMPLE_BITS-1:0] tom3_level;
        logic [SAMPLE_BITS-1:0] ride_level;
        logic [SAMPLE_BITS-1:0] kick_level;
        logic [SAMPLE_BITS-1:0] hihat_level;
        logic [SAMPLE_BITS-1:0] pedal_level;
        logic [TIME_BITS-1:0]   now_ticks;
    } in_item_t;

    typedef struct packed {
        logic       is_note_on;
        logic [6:0] note_number;
        logic [6:0] velocity;
        logic       last;
    } out_item_t;

    function automatic logic [6:0] slot_note(input logic [2:0] slot);
        logic [6:0] n;
        unique case (slot)
            3'd0:    n = NOTE_CRASH;
            3'd1:    n = NOTE_TOM1;
            3'd2:    n = NOTE_TOM2;
            3'd3:    n = NOTE_TOM3;
            3'd4:    n = NOTE_RIDE;
            3'd5:    n = NOTE_KICK;
            default: n = NOTE_HIHAT_OPEN;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

[rtl/drum_pad_trigger_to_midi.sv]
// ----------------------------------------------------------------------------
// drum_pad_trigger_to_midi
// Drum pad trigger scanner producing MIDI note-on and note-off beats.
// ----------------------------------------------------------------------------
// A scan takes the sequencer through the regular pad steps, then the pedal, divider,
// hi-hat, pedal note-off and flush steps, the divider step only when a pedal close
// is timed, as the velocity drop comes from a one bit per cycle divider; the next
// scan is taken in idle. A full output queue stalls. Each event is held until the
// next one of its scan is found or the scan ends, then enters the output queue.
// Reset is asynchronous, active low: all pads idle, pedal open, registers at defaults.
`default_nettype none

module drum_pad_trigger_to_midi #(
    parameter int REGULAR_PADS = 6
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire dpt_pkg::in_item_t            in_item,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output dpt_pkg::out_item_t                out_item,
    input  wire logic                         cfg_we,
    input  wire logic [2:0]                   cfg_index,
    input  wire logic [dpt_pkg::CFG_BITS-1:0] cfg_data
);
    import dpt_pkg::*;

    // The sequencer holds back each event until it knows whether a later one
    // follows, so the last flag is exact; the queue decouples the sequencer
    // from back pressure on the output channel.
    logic      q_push, q_ready;
    out_item_t q_item;

    dpt_front #(
        .REGULAR_PADS (REGULAR_PADS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_push    (q_push),
        .q_item    (q_item),
        .q_ready   (q_ready)
    );

    dpt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_item),
        .push_ready (q_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

endmodule

`default_nettype wire

[rtl/dpt_div.sv]
// ----------------------------------------------------------------------------
// dpt_div
// Restoring divider, one quotient bit per cycle, for the pedal velocity drop.
// ----------------------------------------------------------------------------
`default_nettype none

module dpt_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [dpt_pkg::TIME_BITS-1:0] dividend,
    input  wire logic [dpt_pkg::TIME_BITS-1:0] divisor,
    output logic                               busy,
    output logic [dpt_pkg::TIME_BITS-1:0]      quotient
);
    import dpt_pkg::*;

    localparam int CNT_BITS = $clog2(TIME_BITS + 1);

    logic [TIME_BITS:0]    rem_reg, rem_next;
    logic [TIME_BITS-1:0]  quo_reg, quo_next;
    logic [TIME_BITS-1:0]  div_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic                  busy_reg;
    logic [TIME_BITS:0]    shifted;

    always_comb
    begin
        shifted = {rem_reg[TIME_BITS-1:0], quo_reg[TIME_BITS-1]};
        if (shifted >= {1'b0, div_reg})
        begin
            rem_next = shifted - {1'b0, div_reg};
            quo_next = {quo_reg[TIME_BITS-2:0], 1'b1};
        end
        else
        begin
            rem_next = shifted;
            quo_next = {quo_reg[TIME_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            div_reg  <= TIME_BITS'(1);
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_BITS'(TIME_BITS);
            rem_reg  <= '0;
            quo_reg  <= dividend;
            div_reg  <= (divisor == '0) ? TIME_BITS'(1) : divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

[rtl/dpt_queue.sv]
// ----------------------------------------------------------------------------
// dpt_queue
// Small event queue between the scan sequencer and the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module dpt_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire dpt_pkg::out_item_t push_item,
    output logic                    push_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output dpt_pkg::out_item_t      out_item
);
    import dpt_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_BITS = $clog2(DEPTH);

    out_item_t             mem_reg [0:DEPTH-1];
    logic [PTR_BITS-1:0]   head_reg, tail_reg;
    logic [PTR_BITS:0]     cnt_reg;
    logic                  do_push, do_pop;

    assign push_ready = (cnt_reg != (PTR_BITS+1)'(DEPTH));
    assign out_valid  = (cnt_reg != '0);
    assign out_item   = mem_reg[head_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[tail_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                tail_reg <= tail_reg + 1'b1;
            end
            if (do_pop)
            begin
                head_reg <= head_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/dpt_front.sv]
// ----------------------------------------------------------------------------
// dpt_front
// Scan sequencer: walks the pads, the pedal and the pedal note-off one step
// per cycle unless stalled by queue or divider; posts MIDI events to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dpt_front #(
    parameter int REGULAR_PADS = 6
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire dpt_pkg::in_item_t            in_item,
    input  wire logic                         cfg_we,
    input  wire logic [2:0]                   cfg_index,
    input  wire logic [dpt_pkg::CFG_BITS-1:0] cfg_data,
    output logic                              q_push,
    output dpt_pkg::out_item_t                q_item,
    input  wire logic                         q_ready
);
    import dpt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_PAD, S_PEDAL, S_DIV, S_HIHAT, S_POFF, S_FLUSH
    } state_t;

    state_t                 state_reg;
    logic [2:0]             slot_reg;
    in_item_t               scan_reg;
    logic [3:0]             cnt_reg;
    logic                   pend_valid_reg;
    out_item_t              pend_reg;
    logic                   was_sounding_reg;

    logic [SAMPLE_BITS-1:0] thr_reg, open_lvl_reg, closed_lvl_reg;
    logic [TIME_BITS-1:0]   hold_reg, window_reg, vdiv_reg;

    logic [1:0]             phase_reg [0:PAD_SLOTS-1];
    logic [SAMPLE_BITS-1:0] peak_reg  [0:PAD_SLOTS-1];
    logic [TIME_BITS-1:0]   start_reg [0:PAD_SLOTS-1];
    logic                   closed_pitch_reg;
    logic [1:0]             pos_reg;
    logic [TIME_BITS-1:0]   open_time_reg, note_time_reg;
    logic                   sounding_reg, rearmed_reg;

    logic [SAMPLE_BITS-1:0] lv;
    logic [1:0]             ph;
    logic [TIME_BITS-1:0]   pad_el, open_el, note_el, quotient;
    logic [6:0]             note_cur, ped_vel;
    logic                   ev_req, room, step_go, fire, div_busy, div_start;
    logic                   hh_free, ped_open, ped_semi;
    out_item_t              ev_item;

    always_comb
    begin
        unique case (slot_reg)
            3'd0:    lv = scan_reg.crash_level;
            3'd1:    lv = scan_reg.tom1_level;
            3'd2:    lv = scan_reg.tom2_level;
            3'd3:    lv = scan_reg.tom3_level;
            3'd4:    lv = scan_reg.ride_level;
            3'd5:    lv = scan_reg.kick_level;
            default: lv = scan_reg.hihat_level;
        endcase
    end

    assign ph       = phase_reg[slot_reg];
    assign pad_el   = scan_reg.now_ticks - start_reg[slot_reg];
    assign open_el  = scan_reg.now_ticks - open_time_reg;
    assign note_el  = scan_reg.now_ticks - note_time_reg;
    assign note_cur = (state_reg == S_HIHAT)
                      ? (closed_pitch_reg ? NOTE_HIHAT_CLOSED : NOTE_HIHAT_OPEN)
                      : slot_note(slot_reg);
    assign ped_vel  = (quotient >= TIME_BITS'(127))
                      ? 7'd0 : (VEL_MAX - quotient[6:0]);
    assign hh_free  = (phase_reg[HIHAT_SLOT] != PH_WAIT) &&
                      (phase_reg[HIHAT_SLOT] != PH_ON);
    assign ped_open = scan_reg.pedal_level > open_lvl_reg;
    assign ped_semi = scan_reg.pedal_level > closed_lvl_reg;

    // One candidate event per step.
    always_comb
    begin
        ev_req  = 1'b0;
        ev_item = '0;
        unique case (state_reg)
            S_PAD, S_HIHAT:
            begin
                ev_item.note_number = note_cur;
                if (ph == PH_WAIT && lv <= peak_reg[slot_reg])
                begin
                    ev_req             = 1'b1;
                    ev_item.is_note_on = 1'b1;
                    ev_item.velocity   = peak_reg[slot_reg][SAMPLE_BITS-1:VEL_SHIFT];
                end
                else if (ph == PH_ON && pad_el >= hold_reg)
                begin
                    ev_req = 1'b1;
                end
            end
            S_DIV:
            begin
                ev_req              = !div_busy;
                ev_item.is_note_on  = 1'b1;
                ev_item.note_number = NOTE_PEDAL;
                ev_item.velocity    = ped_vel;
            end
            S_POFF:
            begin
                ev_req              = was_sounding_reg && (note_el >= hold_reg);
                ev_item.note_number = NOTE_PEDAL;
            end
            default:
            begin
                ev_req = 1'b0;
            end
        endcase
    end

    assign room     = (cnt_reg < 4'(MAX_EVENTS));
    assign step_go  = !pend_valid_reg || q_ready;
    assign fire     = ev_req && room && step_go;
    assign in_ready = (state_reg == S_IDLE);
    assign div_start = (state_reg == S_PEDAL) && hh_free && !ped_open && !ped_semi &&
                       rearmed_reg && (open_el <= window_reg);

    // The held event goes out once its successor exists or the scan ends.
    always_comb
    begin
        q_push = 1'b0;
        q_item = pend_reg;
        if (state_reg == S_FLUSH)
        begin
            q_push      = pend_valid_reg && q_ready;
            q_item.last = 1'b1;
        end
        else if (fire && pend_valid_reg)
        begin
            q_push      = 1'b1;
            q_item.last = 1'b0;
        end
    end

    dpt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (open_el),
        .divisor  (vdiv_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            slot_reg         <= '0;
            scan_reg         <= '0;
            cnt_reg          <= '0;
            pend_valid_reg   <= 1'b0;
            pend_reg         <= '0;
            was_sounding_reg <= 1'b0;
            thr_reg          <= SAMPLE_BITS'(10);
            hold_reg         <= TIME_BITS'(7812);
            open_lvl_reg     <= SAMPLE_BITS'(930);
            closed_lvl_reg   <= SAMPLE_BITS'(600);
            window_reg       <= TIME_BITS'(7812);
            vdiv_reg         <= TIME_BITS'(62);
            for (int i = 0; i < PAD_SLOTS; i++)
            begin
                phase_reg[i] <= PH_IDLE;
                peak_reg[i]  <= '0;
                start_reg[i] <= '0;
            end
            closed_pitch_reg <= 1'b0;
            pos_reg          <= POS_OPEN;
            open_time_reg    <= '0;
            note_time_reg    <= '0;
            sounding_reg     <= 1'b0;
            rearmed_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_NOTE_THRESHOLD: thr_reg        <= cfg_data[SAMPLE_BITS-1:0];
                    CFG_NOTE_HOLD:      hold_reg       <= cfg_data[TIME_BITS-1:0];
                    CFG_PEDAL_OPEN:     open_lvl_reg   <= cfg_data[SAMPLE_BITS-1:0];
                    CFG_PEDAL_CLOSED:   closed_lvl_reg <= cfg_data[SAMPLE_BITS-1:0];
                    CFG_PEDAL_WINDOW:   window_reg     <= cfg_data[TIME_BITS-1:0];
                    CFG_PEDAL_VEL_DIV:  vdiv_reg       <= cfg_data[TIME_BITS-1:0];
                    default:            thr_reg        <= thr_reg;
                endcase
            end

            if (fire)
            begin
                pend_valid_reg <= 1'b1;
                pend_reg       <= ev_item;
                cnt_reg        <= cnt_reg + 1'b1;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        scan_reg         <= in_item;
                        slot_reg         <= '0;
                        cnt_reg          <= '0;
                        was_sounding_reg <= sounding_reg;
                        state_reg        <= S_PAD;
                    end
                end
                S_PAD, S_HIHAT:
                begin
                    if (step_go)
                    begin
                        if (ph == PH_WAIT)
                        begin
                            if (lv > peak_reg[slot_reg])
                            begin
                                peak_reg[slot_reg] <= lv;
                            end
                            else if (fire)
                            begin
                                start_reg[slot_reg] <= scan_reg.now_ticks;
                                phase_reg[slot_reg] <= PH_ON;
                            end
                        end
                        else if (ph == PH_ON)
                        begin
                            if (fire)
                            begin
                                phase_reg[slot_reg] <= PH_IDLE;
                            end
                        end
                        else if (lv >= thr_reg)
                        begin
                            peak_reg[slot_reg]  <= lv;
                            phase_reg[slot_reg] <= PH_WAIT;
                        end
                        if (state_reg == S_HIHAT)
                        begin
                            state_reg <= S_POFF;
                        end
                        else if (slot_reg == 3'(REGULAR_PADS - 1))
                        begin
                            slot_reg  <= HIHAT_SLOT;
                            state_reg <= S_PEDAL;
                        end
                        else
                        begin
                            slot_reg <= slot_reg + 1'b1;
                        end
                    end
                end
                S_PEDAL:
                begin
                    if (ped_open)
                    begin
                        pos_reg       <= POS_OPEN;
                        open_time_reg <= scan_reg.now_ticks;
                        rearmed_reg   <= 1'b1;
                    end
                    else if (ped_semi)
                    begin
                        pos_reg <= POS_SEMI;
                    end
                    else
                    begin
                        pos_reg <= POS_CLOSED;
                    end
                    if (hh_free)
                    begin
                        closed_pitch_reg <= !ped_open && !ped_semi;
                    end
                    state_reg <= div_start ? S_DIV : S_HIHAT;
                end
                S_DIV:
                begin
                    if (!div_busy && step_go)
                    begin
                        if (fire)
                        begin
                            sounding_reg  <= 1'b1;
                            note_time_reg <= scan_reg.now_ticks;
                            rearmed_reg   <= 1'b0;
                        end
                        state_reg <= S_HIHAT;
                    end
                end
                S_POFF:
                begin
                    if (step_go)
                    begin
                        if (fire)
                        begin
                            sounding_reg <= 1'b0;
                        end
                        state_reg <= S_FLUSH;
                    end
                end
                S_FLUSH:
                begin
                    if (!pend_valid_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (q_ready)
                    begin
                        pend_valid_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // A scan never yields more events than the limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 4'(MAX_EVENTS))
        else $error("event count above limit");

    // No event is held over from one scan into the next.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !pend_valid_reg)
        else $error("held event left at scan end");

    // Events are only posted when the queue has room.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> q_ready)
        else $error("push into full queue");

    // A timed pedal close starts the divider and moves to S_DIV, where the pedal note-on waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> state_reg == S_DIV && div_busy)
        else $error("divider not started");

endmodule

`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives trigger scans into the drum pad block, predicts every MIDI beat
// with an independent model of the pad, hi-hat and pedal logic, and checks
// each output beat field by field against the oldest predicted event.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import dpt_pkg::*;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_item_t in_item;
    logic out_valid;
    logic out_ready;
    out_item_t out_item;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [CFG_BITS-1:0] cfg_data;

    drum_pad_trigger_to_midi i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Shadow copy of the configuration registers.
    logic [9:0]  threshold_q;
    logic [15:0] hold_q;
    logic [9:0]  open_lvl_q;
    logic [9:0]  closed_lvl_q;
    logic [15:0] window_q;
    logic [15:0] div_q;

    // Shadow copy of the block state. Slot 6 is the hi-hat pad.
    logic [1:0]  phase_q [7];
    logic [9:0]  peak_q [7];
    logic [15:0] start_q [7];
    logic        hh_closed_q;
    logic [1:0]  pos_q;
    logic [15:0] open_time_q;
    logic [15:0] pedal_on_time_q;
    logic        pedal_sounding_q;
    logic        rearmed_q;

    out_item_t midi_expected[$];
    out_item_t scan_events[$];

    int  errors;
    int  cycles;
    bit  in_quiet;
    bit  out_quiet;
    logic [15:0] tick_now;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Generous cycle limit: 450+ scans, each with many cycles of work and
    // stalls on both sides, stays far below this.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: random stalls except during a quiet stretch.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= out_quiet ? 1'b1 : ($urandom_range(99) >= 24);
    end

    // Each accepted output beat is compared with the oldest predicted event.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (midi_expected.size() == 0)
            begin
                $display("%0t: unexpected beat %h", $realtime, out_item);
                errors++;
            end
            else
            begin
                out_item_t e;
                e = midi_expected.pop_front();
                if (e.is_note_on !== out_item.is_note_on)
                begin
                    $display("%0t: is_note_on expected %0d actual %0d", $realtime,
                             e.is_note_on, out_item.is_note_on);
                    errors++;
                end
                if (e.note_number !== out_item.note_number)
                begin
                    $display("%0t: note_number expected %0d actual %0d", $realtime,
                             e.note_number, out_item.note_number);
                    errors++;
                end
                if (e.velocity !== out_item.velocity)
                begin
                    $display("%0t: velocity expected %0d actual %0d", $realtime,
                             e.velocity, out_item.velocity);
                    errors++;
                end
                if (e.last !== out_item.last)
                begin
                    $display("%0t: last expected %0d actual %0d", $realtime,
                             e.last, out_item.last);
                    errors++;
                end
            end
        end
    end

    // Appends an event unless this scan already has the maximum number.
    // A refused event leaves the state unchanged so it retries later.
    function automatic bit post_event(input bit on, input logic [6:0] note,
                                      input logic [6:0] vel);
        out_item_t ev;
        if (scan_events.size() >= MAX_EVENTS)
            return 1'b0;
        ev.is_note_on = on;
        ev.note_number = note;
        ev.velocity = vel;
        ev.last = 1'b0;
        scan_events.push_back(ev);
        return 1'b1;
    endfunction

    // One pad's trigger state machine: arm at or above threshold, track the peak,
    // sound at the first non-rising sample, release after the hold time.
    function automatic void step_pad(input int slot, input logic [9:0] level,
                                     input logic [6:0] note, input logic [15:0] now);
        logic [15:0] held;
        held = now - start_q[slot];
        if (phase_q[slot] == PH_WAIT)
        begin
            if (level > peak_q[slot])
                peak_q[slot] = level;
            else if (post_event(1'b1, note, 7'(peak_q[slot] >> VEL_SHIFT)))
            begin
                start_q[slot] = now;
                phase_q[slot] = PH_ON;
            end
        end
        else if (phase_q[slot] == PH_ON)
        begin
            if (held >= hold_q && post_event(1'b0, note, 7'd0))
                phase_q[slot] = PH_IDLE;
        end
        else if (level >= threshold_q)
        begin
            peak_q[slot] = level;
            phase_q[slot] = PH_WAIT;
        end
    endfunction

    // Predicts the MIDI events of one scan and queues them.
    function automatic void predict_scan(input in_item_t s);
        logic [9:0]  lv [6];
        logic [6:0]  notes [6];
        logic [15:0] gap;
        logic [15:0] divisor;
        int unsigned drop;
        bit was_sounding;
        lv[0] = s.crash_level; lv[1] = s.tom1_level; lv[2] = s.tom2_level;
        lv[3] = s.tom3_level;  lv[4] = s.ride_level; lv[5] = s.kick_level;
        notes[0] = NOTE_CRASH; notes[1] = NOTE_TOM1; notes[2] = NOTE_TOM2;
        notes[3] = NOTE_TOM3;  notes[4] = NOTE_RIDE; notes[5] = NOTE_KICK;
        was_sounding = pedal_sounding_q;
        scan_events.delete();
        for (int i = 0; i < 6; i++)
            step_pad(i, lv[i], notes[i], s.now_ticks);
        // Open is tested before semi-open, so contradictory levels read open.
        if (s.pedal_level > open_lvl_q)
        begin
            pos_q = POS_OPEN;
            open_time_q = s.now_ticks;
            rearmed_q = 1'b1;
        end
        else if (s.pedal_level > closed_lvl_q)
            pos_q = POS_SEMI;
        else
            pos_q = POS_CLOSED;
        // The hi-hat pitch only follows the pedal while the pad is idle.
        if (phase_q[HIHAT_SLOT] != PH_WAIT && phase_q[HIHAT_SLOT] != PH_ON)
        begin
            if (pos_q == POS_CLOSED)
            begin
                hh_closed_q = 1'b1;
                gap = s.now_ticks - open_time_q;
                if (rearmed_q && gap <= window_q)
                begin
                    divisor = (div_q == 16'd0) ? 16'd1 : div_q;
                    drop = gap / divisor;
                    if (post_event(1'b1, NOTE_PEDAL,
                                   (drop >= 127) ? 7'd0 : 7'(127 - drop)))
                    begin
                        pedal_sounding_q = 1'b1;
                        pedal_on_time_q = s.now_ticks;
                        rearmed_q = 1'b0;
                    end
                end
            end
            else
                hh_closed_q = 1'b0;
        end
        step_pad(HIHAT_SLOT, s.hihat_level,
                 hh_closed_q ? NOTE_HIHAT_CLOSED : NOTE_HIHAT_OPEN, s.now_ticks);
        gap = s.now_ticks - pedal_on_time_q;
        if (was_sounding && gap >= hold_q && post_event(1'b0, NOTE_PEDAL, 7'd0))
            pedal_sounding_q = 1'b0;
        if (scan_events.size() > 0)
            scan_events[scan_events.size() - 1].last = 1'b1;
        foreach (scan_events[k])
            midi_expected.push_back(scan_events[k]);
    endfunction

    // Sends one scan, holding it until the block takes the beat.
    task automatic send_scan(input in_item_t s);
        while (!in_quiet && $urandom_range(99) < 24)
            @(posedge clk);
        in_valid <= 1'b1;
        in_item <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_scan(s);
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Builds a scan with all six pad levels at one value, given hi-hat and pedal levels, and advances the tick time.
    function automatic in_item_t flat_scan(input logic [9:0] pads, input logic [9:0] hh,
                                           input logic [9:0] pedal, input logic [15:0] dt);
        in_item_t s;
        tick_now = tick_now + dt;
        s.crash_level = pads; s.tom1_level = pads; s.tom2_level = pads;
        s.tom3_level = pads;  s.ride_level = pads; s.kick_level = pads;
        s.hihat_level = hh;
        s.pedal_level = pedal;
        s.now_ticks = tick_now;
        return s;
    endfunction

    // Waits until every predicted beat has arrived, plus a settling margin.
    task automatic drain;
        while (midi_expected.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Writes one register while the block is idle and updates the shadow copy.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_NOTE_THRESHOLD: threshold_q = val[9:0];
            CFG_NOTE_HOLD:      hold_q = val;
            CFG_PEDAL_OPEN:     open_lvl_q = val[9:0];
            CFG_PEDAL_CLOSED:   closed_lvl_q = val[9:0];
            CFG_PEDAL_WINDOW:   window_q = val;
            CFG_PEDAL_VEL_DIV:  div_q = val;
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [9:0] thr, input logic [15:0] hold,
                             input logic [9:0] opn, input logic [9:0] cls,
                             input logic [15:0] win, input logic [15:0] dv);
        drain();
        write_reg(CFG_NOTE_THRESHOLD, 16'(thr));
        write_reg(CFG_NOTE_HOLD, hold);
        write_reg(CFG_PEDAL_OPEN, 16'(opn));
        write_reg(CFG_PEDAL_CLOSED, 16'(cls));
        write_reg(CFG_PEDAL_WINDOW, win);
        write_reg(CFG_PEDAL_VEL_DIV, dv);
    endtask

    // Full-scale hits on all pads, the zero and maximum levels, and every
    // pad releasing in the same scan, which stays below the eight-event limit.
    task automatic test_pad_extremes;
        send_scan(flat_scan(10'd1023, 10'd1023, 10'd1023, 16'd1));
        send_scan(flat_scan(10'd0, 10'd0, 10'd1023, 16'd1));
        send_scan(flat_scan(10'd0, 10'd0, 10'd1023, 16'd8000));
        send_scan(flat_scan(10'd0, 10'd0, 10'd1023, 16'd1));
        send_scan(flat_scan(10'd9, 10'd9, 10'd1023, 16'd1));
        send_scan(flat_scan(10'd10, 10'd10, 10'd1023, 16'd1));
        send_scan(flat_scan(10'd500, 10'd500, 10'd1023, 16'd1));
        send_scan(flat_scan(10'd0, 10'd0, 10'd1023, 16'd1));
    endtask

    // Pedal open, semi, then a fast close and a slow close; hi-hat pitch
    // follows the pedal; the zero divider and contradictory levels.
    task automatic test_pedal;
        write_all(10'd10, 16'd100, 10'd930, 10'd600, 16'd7812, 16'd0);
        send_scan(flat_scan(10'd0, 10'd0, 10'd1000, 16'd200));
        send_scan(flat_scan(10'd0, 10'd0, 10'd700, 16'd3));
        send_scan(flat_scan(10'd0, 10'd400, 10'd100, 16'd3));
        send_scan(flat_scan(10'd0, 10'd0, 10'd100, 16'd3));
        send_scan(flat_scan(10'd0, 10'd0, 10'd100, 16'd200));
        send_scan(flat_scan(10'd0, 10'd0, 10'd100, 16'd200));
        write_all(10'd10, 16'd100, 10'd300, 10'd800, 16'd65535, 16'd1);
        send_scan(flat_scan(10'd0, 10'd0, 10'd500, 16'd10));
        send_scan(flat_scan(10'd0, 10'd0, 10'd0, 16'd50000));
        send_scan(flat_scan(10'd0, 10'd0, 10'd0, 16'd200));
        // The sender holds off here until every predicted beat has arrived.
        drain();
    endtask

    // Random scans under several register settings. Most scans give each pad a
    // random level about one time in four, with a random pedal; some are pure noise.
    task automatic test_random(input int count);
        in_item_t s;
        for (int n = 0; n < count; n++)
        begin
            if (n % 90 == 0)
            begin
                case ((n / 90) % 5)
                    0: write_all(10'd10, 16'd7812, 10'd930, 10'd600, 16'd7812, 16'd62);
                    1: write_all(10'd0, 16'd0, 10'd0, 10'd0, 16'd0, 16'd1);
                    2: write_all(10'd1023, 16'd65535, 10'd1023, 10'd1023,
                                 16'd65535, 16'd65535);
                    3: write_all(10'($urandom_range(1023)), 16'($urandom_range(3000)),
                                 10'($urandom_range(1023)), 10'($urandom_range(1023)),
                                 16'($urandom_range(65535)), 16'($urandom_range(300)));
                    default: write_all(10'd200, 16'd400, 10'd800, 10'd300,
                                       16'd2000, 16'd10);
                endcase
                // Quiet stretch with no idling on either side.
                in_quiet = (((n / 90) % 5) == 2);
                out_quiet = in_quiet;
            end
            if ($urandom_range(99) < 15)
            begin
                s = in_item_t'(96'({$urandom, $urandom, $urandom, $urandom}));
                tick_now = s.now_ticks;
            end
            else
            begin
                s = flat_scan(10'd0, 10'd0, 10'd0, 16'($urandom_range(700)));
                s.crash_level = 10'($urandom_range(3) == 0 ? $urandom_range(1023) : 0);
                s.tom1_level  = 10'($urandom_range(3) == 0 ? $urandom_range(1023) : 0);
                s.tom2_level  = 10'($urandom_range(3) == 0 ? $urandom_range(1023) : 0);
                s.tom3_level  = 10'($urandom_range(3) == 0 ? $urandom_range(1023) : 0);
                s.ride_level  = 10'($urandom_range(3) == 0 ? $urandom_range(1023) : 0);
                s.kick_level  = 10'($urandom_range(3) == 0 ? $urandom_range(1023) : 0);
                s.hihat_level = 10'($urandom_range(3) == 0 ? $urandom_range(1023) : 0);
                s.pedal_level = 10'($urandom_range(1) ? $urandom_range(1023)
                                                      : $urandom_range(150));
            end
            send_scan(s);
        end
        in_quiet = 1'b0;
        out_quiet = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_NOTE_THRESHOLD;
        cfg_data = '0;
        errors = 0;
        cycles = 0;
        in_quiet = 1'b0;
        out_quiet = 1'b0;
        tick_now = 16'd0;
        threshold_q = 10'd10;
        hold_q = 16'd7812;
        open_lvl_q = 10'd930;
        closed_lvl_q = 10'd600;
        window_q = 16'd7812;
        div_q = 16'd62;
        for (int i = 0; i < 7; i++)
        begin
            phase_q[i] = PH_IDLE;
            peak_q[i] = '0;
            start_q[i] = '0;
        end
        hh_closed_q = 1'b0;
        pos_q = POS_OPEN;
        open_time_q = '0;
        pedal_on_time_q = '0;
        pedal_sounding_q = 1'b0;
        rearmed_q = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_pad_extremes();
        test_pedal();
        test_random(450);

        drain();
        if (errors == 0 && midi_expected.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
rtl/dpt_pkg.sv
rtl/dpt_div.sv
rtl/dpt_queue.sv
rtl/dpt_front.sv
rtl/drum_pad_trigger_to_midi.sv
tb/testbench.sv
